// ===== hdl/tpc_pkg.sv =====
// Package with shared widths, register indexes and limits of the temperature calibration block.
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

	// Field widths.
	localparam int RAW_W   = 16;
	localparam int TEMP_W  = 12;
	localparam int DEG_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 16;

	// Internal datapath widths.
	localparam int DIFF_W = RAW_W + 1;
	localparam int PROD_W = DIFF_W + DEG_W + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int NUM_W  = SUM_W + 4;
	localparam int DIV_BITS = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH_BITS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT0_DEGX8_LOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT1_DEGX8_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POINT0_RAW       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POINT1_RAW       = 3'd4;

	// Clamp limits in tenths of a degree.
	localparam logic [DIV_BITS-1:0] UPPER_LIMIT_MAG = 11'd1200;
	localparam logic [DIV_BITS-1:0] LOWER_LIMIT_MAG = 11'd400;
	localparam logic signed [TEMP_W-1:0] UPPER_SAT = 12'sd1199;
	localparam logic signed [TEMP_W-1:0] LOWER_SAT = -12'sd399;

endpackage

`default_nettype wire

// ===== hdl/temperature_two_point_calibration.sv =====
// Top level of the two-point temperature calibration pipeline.
//
// Usage: raw signed samples enter on the s_axis channel (s_tdata[15:0]) and
// calibrated results leave on the m_axis channel. Each transaction in gives
// exactly one transaction out, in order. Calibration points are written on
// the cfg_we / cfg_index / cfg_wdata port while no sample is in flight.
//
// The datapath is a 17-stage pipeline: operand differences, two 17x8
// multiplies, the sum, the scale by ten, magnitude extraction, eleven
// restoring divider stages (one quotient bit each) and the clamp stage that
// also serves as the output register. One sample is accepted every cycle
// unless a stall on m_tready has filled every stage.
//
// Each stage holds its item while the stage after it is full and stalled, so
// a stall on m_tready fills empty stages first; s_tready falls only when all
// stages hold items. Nothing is lost or repeated under stalls.
//
// Reset clears the valid bits of every stage and all calibration registers
// to zero; the pipeline is empty and ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module temperature_two_point_calibration (
	input  wire                               clk,
	input  wire                               arst_n,
	// Configuration write port.
	input  wire                               cfg_we,
	input  wire [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [tpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Sample input stream.
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [tpc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] raw_sample
	// Result output stream.
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [tpc_pkg::OUT_TDATA_W-1:0]   m_tdata    // [11:0] temp_tenths, [12] clamped,
	                                                     // [13] div_error, [15:14] zero
);

	localparam int DIV_FIRST = 5;
	localparam int NST = DIV_FIRST + tpc_pkg::DIV_BITS + 1;
	localparam int ST_OUT = NST - 1;
	localparam int NUM_W = tpc_pkg::NUM_W;
	localparam int DIFF_W = tpc_pkg::DIFF_W;
	localparam int PROD_W = tpc_pkg::PROD_W;
	localparam int SUM_W = tpc_pkg::SUM_W;
	localparam int DEG_W = tpc_pkg::DEG_W;
	localparam int DIV_BITS = tpc_pkg::DIV_BITS;
	localparam int TEMP_W = tpc_pkg::TEMP_W;

	// Calibration registers.
	logic [7:0]  cal_high_bits_q;
	logic [7:0]  point0_degx8_low_q;
	logic [7:0]  point1_degx8_low_q;
	logic [15:0] point0_raw_q;
	logic [15:0] point1_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_high_bits_q    <= '0;
			point0_degx8_low_q <= '0;
			point1_degx8_low_q <= '0;
			point0_raw_q       <= '0;
			point1_raw_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpc_pkg::REG_CAL_HIGH_BITS:    cal_high_bits_q    <= cfg_wdata[7:0];
				tpc_pkg::REG_POINT0_DEGX8_LOW: point0_degx8_low_q <= cfg_wdata[7:0];
				tpc_pkg::REG_POINT1_DEGX8_LOW: point1_degx8_low_q <= cfg_wdata[7:0];
				tpc_pkg::REG_POINT0_RAW:       point0_raw_q       <= cfg_wdata;
				tpc_pkg::REG_POINT1_RAW:       point1_raw_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or its successor loads.
	logic [NST-1:0] stage_valid_s;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !stage_valid_s[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !stage_valid_s[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_s <= '0;
		end else begin
			if (adv[0]) begin
				stage_valid_s[0] <= s_tvalid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					stage_valid_s[k] <= stage_valid_s[k-1];
				end
			end
		end
	end

	assign s_tready = adv[0];

	// Stage 1: differences against the calibration readings and whole degrees.
	// Dropping the three low bits of each degrees-times-8 value is the floor by 8.
	logic signed [DIFF_W-1:0] a_s1, b_s1, den_s1;
	logic [DEG_W-1:0]         d0_s1, d1_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			a_s1   <= {point1_raw_q[15], point1_raw_q} - {s_tdata[15], s_tdata};
			b_s1   <= {s_tdata[15], s_tdata} - {point0_raw_q[15], point0_raw_q};
			den_s1 <= {point1_raw_q[15], point1_raw_q} - {point0_raw_q[15], point0_raw_q};
			d0_s1  <= {cal_high_bits_q[1:0], point0_degx8_low_q[7:3]};
			d1_s1  <= {cal_high_bits_q[3:2], point1_degx8_low_q[7:3]};
		end
	end

	// Stage 2: weight each difference by the other point's temperature.
	logic signed [PROD_W-1:0] p0_s2, p1_s2;
	logic signed [DIFF_W-1:0] den_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p0_s2  <= PROD_W'(a_s1) * PROD_W'($signed({1'b0, d0_s1}));
			p1_s2  <= PROD_W'(b_s1) * PROD_W'($signed({1'b0, d1_s1}));
			den_s2 <= den_s1;
		end
	end

	// Stage 3: numerator sum.
	logic signed [SUM_W-1:0]  num_s3;
	logic signed [DIFF_W-1:0] den_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			num_s3 <= SUM_W'(p0_s2) + SUM_W'(p1_s2);
			den_s3 <= den_s2;
		end
	end

	// Stage 4: scale by ten, denominator magnitude, result sign and zero check.
	logic signed [NUM_W-1:0]  n10_s4;
	logic [DIFF_W-1:0]        magd_s4;
	logic                     neg_s4, err_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			n10_s4  <= (NUM_W'(num_s3) <<< 3) + (NUM_W'(num_s3) <<< 1);
			magd_s4 <= den_s3[DIFF_W-1] ? DIFF_W'(-den_s3) : DIFF_W'(den_s3);
			neg_s4  <= num_s3[SUM_W-1] ^ den_s3[DIFF_W-1];
			err_s4  <= (den_s3 == '0);
		end
	end

	// Stage 5: numerator magnitude.
	logic [NUM_W-1:0]  magn_s5;
	logic [DIFF_W-1:0] magd_s5;
	logic              neg_s5, err_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			magn_s5 <= n10_s4[NUM_W-1] ? NUM_W'(-n10_s4) : NUM_W'(n10_s4);
			magd_s5 <= magd_s4;
			neg_s5  <= neg_s4;
			err_s5  <= err_s4;
		end
	end

	// Restoring divider stages, one quotient bit per stage from the top down.
	// The first one also flags quotients of 2048 or more, which clamp anyway.
	logic [NUM_W-1:0]    div_rem_sd  [DIV_BITS];
	logic [DIV_BITS-1:0] div_quo_sd  [DIV_BITS];
	logic [DIFF_W-1:0]   div_magd_sd [DIV_BITS];
	logic                div_neg_sd  [DIV_BITS];
	logic                div_err_sd  [DIV_BITS];
	logic                div_ovf_sd  [DIV_BITS];

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
		localparam int B = DIV_BITS - 1 - j;
		logic [NUM_W-1:0]    rem_in;
		logic [DIV_BITS-1:0] quo_in;
		logic [DIFF_W-1:0]   magd_in;
		logic                neg_in, err_in, ovf_in;
		logic [NUM_W-1:0]    dsh;
		logic                ge;

		if (j == 0) begin : g_head
			assign rem_in  = magn_s5;
			assign quo_in  = '0;
			assign magd_in = magd_s5;
			assign neg_in  = neg_s5;
			assign err_in  = err_s5;
			assign ovf_in  = (magn_s5 >= (NUM_W'(magd_s5) << DIV_BITS));
		end else begin : g_body
			assign rem_in  = div_rem_sd[j-1];
			assign quo_in  = div_quo_sd[j-1];
			assign magd_in = div_magd_sd[j-1];
			assign neg_in  = div_neg_sd[j-1];
			assign err_in  = div_err_sd[j-1];
			assign ovf_in  = div_ovf_sd[j-1];
		end

		assign dsh = NUM_W'(magd_in) << B;
		assign ge  = (rem_in >= dsh);

		always_ff @(posedge clk) begin
			if (adv[DIV_FIRST+j]) begin
				div_rem_sd[j]  <= ge ? (rem_in - dsh) : rem_in;
				div_quo_sd[j]  <= quo_in | (ge ? (DIV_BITS'(1) << B) : '0);
				div_magd_sd[j] <= magd_in;
				div_neg_sd[j]  <= neg_in;
				div_err_sd[j]  <= err_in;
				div_ovf_sd[j]  <= ovf_in;
			end
		end
	end

	// Final stage: apply sign, clamp and the equal-readings case.
	logic [DIV_BITS-1:0]      q_mag;
	logic signed [TEMP_W-1:0] temp_next;
	logic                     clamp_next, err_next;

	always_comb begin
		q_mag      = div_quo_sd[DIV_BITS-1];
		err_next   = div_err_sd[DIV_BITS-1];
		clamp_next = 1'b0;
		temp_next  = '0;
		if (err_next) begin
			temp_next = '0;
		end else if (!div_neg_sd[DIV_BITS-1]) begin
			if (div_ovf_sd[DIV_BITS-1] || (q_mag >= tpc_pkg::UPPER_LIMIT_MAG)) begin
				temp_next  = tpc_pkg::UPPER_SAT;
				clamp_next = 1'b1;
			end else begin
				temp_next = $signed(TEMP_W'(q_mag));
			end
		end else begin
			if (div_ovf_sd[DIV_BITS-1] || (q_mag >= tpc_pkg::LOWER_LIMIT_MAG)) begin
				temp_next  = tpc_pkg::LOWER_SAT;
				clamp_next = 1'b1;
			end else begin
				temp_next = -$signed(TEMP_W'(q_mag));
			end
		end
	end

	logic signed [TEMP_W-1:0] temp_s17;
	logic                     clamped_s17, err_s17;

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			temp_s17    <= temp_next;
			clamped_s17 <= clamp_next;
			err_s17     <= err_next;
		end
	end

	assign m_tvalid = stage_valid_s[ST_OUT];
	assign m_tdata  = {2'b00, err_s17, clamped_s17, temp_s17};

endmodule

`default_nettype wire

// ===== hdl/tpc_checker.sv =====
// Port-level checker for the temperature calibration block, with its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module tpc_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [tpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic signed [tpc_pkg::TEMP_W-1:0] temp;
	assign temp = $signed(m_tdata[tpc_pkg::TEMP_W-1:0]);

	// A stalled transaction stays offered and unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	// Equal calibration readings give a zero value and no clamp flag.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> (temp == '0) && !m_tdata[12])
		else $error("div_error result is not zero");

	// A clamped result carries one of the two saturation values.
	a_clamp_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> (temp == tpc_pkg::UPPER_SAT) || (temp == tpc_pkg::LOWER_SAT))
		else $error("clamped result has a wrong value");

	// Every result lies in the calibrated range and the padding stays zero.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (temp <= tpc_pkg::UPPER_SAT) && (temp >= tpc_pkg::LOWER_SAT)
		&& (m_tdata[15:14] == 2'b00))
		else $error("result out of range or padding set");

endmodule

bind temperature_two_point_calibration tpc_checker u_tpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_temperature_two_point_calibration.sv =====
// Self-checking testbench for the two-point temperature calibration pipeline.
`timescale 1ns / 1ps

module tb_temperature_two_point_calibration;

	// Thresholds at which the result is limited, in tenths of a degree.
	localparam longint TEMP_UPPER_LIMIT = 1200;
	localparam longint TEMP_LOWER_LIMIT = -400;
	localparam int     CYCLE_LIMIT      = 400000;
	localparam int     MAX_REPORTS      = 10;
	localparam int     DRAIN_CYCLES     = 40;
	localparam logic [tpc_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_INDEX =
		tpc_pkg::CFG_IDX_W'(tpc_pkg::REG_POINT1_RAW + 1);

	typedef struct packed {
		logic signed [tpc_pkg::TEMP_W-1:0] temp_tenths;
		logic                              clamped;
		logic                              div_error;
	} calib_result_t;

	// Clock, reset and block inputs, all known from time zero.
	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [tpc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [tpc_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] raw_sample
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [tpc_pkg::OUT_TDATA_W-1:0] m_tdata;   // [11:0] temp_tenths, [12] clamped, [13] div_error

	// Local copy of the calibration registers.
	logic [7:0]                        model_high_bits;
	logic [7:0]                        model_p0_degx8_low;
	logic [7:0]                        model_p1_degx8_low;
	logic signed [tpc_pkg::RAW_W-1:0]  model_p0_raw;
	logic signed [tpc_pkg::RAW_W-1:0]  model_p1_raw;

	calib_result_t expected_temps[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int results_checked = 0;
	int clamped_seen = 0;
	int div_error_seen = 0;
	int settings_used = 0;
	int cycle_count = 0;

	temperature_two_point_calibration uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycle_count, expected_temps.size());
		$display("== FAIL ==");
		$finish;
	end

	// Interpolate between the two calibration points and limit the result.
	function automatic calib_result_t predict_temperature(
			input logic signed [tpc_pkg::RAW_W-1:0] sample);
		longint        deg0;
		longint        deg1;
		longint        raw0;
		longint        raw1;
		longint        s;
		longint        den;
		longint        num;
		longint        t;
		calib_result_t res;
		deg0 = longint'({model_high_bits[1:0], model_p0_degx8_low}) >> 3;
		deg1 = longint'({model_high_bits[3:2], model_p1_degx8_low}) >> 3;
		raw0 = model_p0_raw;
		raw1 = model_p1_raw;
		s = sample;
		den = raw1 - raw0;
		res = '0;
		if (den == 0) begin
			res.div_error = 1'b1;
		end else begin
			num = (raw1 - s) * deg0 + (s - raw0) * deg1;
			// Signed division truncates toward zero.
			t = (num * 10) / den;
			if (t >= TEMP_UPPER_LIMIT) begin
				res.temp_tenths = tpc_pkg::UPPER_SAT;
				res.clamped = 1'b1;
			end else if (t <= TEMP_LOWER_LIMIT) begin
				res.temp_tenths = tpc_pkg::LOWER_SAT;
				res.clamped = 1'b1;
			end else begin
				res.temp_tenths = t[tpc_pkg::TEMP_W-1:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("Mismatch at cycle %0d in %s: expected %0d, got %0d",
				cycle_count, what, want, got);
		end
	endtask

	// Compare every output transaction with the oldest expectation; drive random stalls.
	always @(posedge clk) begin : result_monitor
		calib_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_temps.size() == 0) begin
				report_mismatch("unexpected result, temp_tenths",
					0, $signed(m_tdata[tpc_pkg::TEMP_W-1:0]));
			end else begin
				want = expected_temps.pop_front();
				results_checked++;
				if (want.clamped) clamped_seen++;
				if (want.div_error) div_error_seen++;
				if (m_tdata[tpc_pkg::TEMP_W-1:0] !== want.temp_tenths)
					report_mismatch("temp_tenths", want.temp_tenths,
						$signed(m_tdata[tpc_pkg::TEMP_W-1:0]));
				if (m_tdata[tpc_pkg::TEMP_W] !== want.clamped)
					report_mismatch("clamped", want.clamped, m_tdata[tpc_pkg::TEMP_W]);
				if (m_tdata[tpc_pkg::TEMP_W+1] !== want.div_error)
					report_mismatch("div_error", want.div_error,
						m_tdata[tpc_pkg::TEMP_W+1]);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offer one sample, with random idle cycles first, and record its expected result.
	task automatic send_sample(input logic [tpc_pkg::RAW_W-1:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= raw;
		do @(posedge clk); while (!s_tready);
		expected_temps.push_back(predict_temperature(raw));
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_temps.size() != 0);
	endtask

	task automatic write_register(input logic [tpc_pkg::CFG_IDX_W-1:0] idx,
			input logic [tpc_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			tpc_pkg::REG_CAL_HIGH_BITS:    model_high_bits    = data[7:0];
			tpc_pkg::REG_POINT0_DEGX8_LOW: model_p0_degx8_low = data[7:0];
			tpc_pkg::REG_POINT1_DEGX8_LOW: model_p1_degx8_low = data[7:0];
			tpc_pkg::REG_POINT0_RAW:       model_p0_raw       = data;
			tpc_pkg::REG_POINT1_RAW:       model_p1_raw       = data;
			default: ;
		endcase
	endtask

	// Load a full calibration setting once the pipeline is empty. The byte
	// registers get random upper bits, and one write goes to an unused index.
	task automatic configure(input logic [7:0] high_bits, input logic [7:0] p0_low,
			input logic [7:0] p1_low, input logic [tpc_pkg::RAW_W-1:0] p0_raw,
			input logic [tpc_pkg::RAW_W-1:0] p1_raw);
		logic [tpc_pkg::CFG_IDX_W-1:0] unused_idx;
		wait_drained();
		unused_idx = FIRST_UNUSED_INDEX + tpc_pkg::CFG_IDX_W'($urandom_range(2));
		write_register(tpc_pkg::REG_CAL_HIGH_BITS, {8'($urandom), high_bits});
		write_register(tpc_pkg::REG_POINT0_DEGX8_LOW, {8'($urandom), p0_low});
		write_register(tpc_pkg::REG_POINT1_DEGX8_LOW, {8'($urandom), p1_low});
		write_register(tpc_pkg::REG_POINT0_RAW, p0_raw);
		write_register(tpc_pkg::REG_POINT1_RAW, p1_raw);
		write_register(unused_idx, 16'($urandom));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic configure_random();
		logic [tpc_pkg::RAW_W-1:0] p0_raw;
		logic [tpc_pkg::RAW_W-1:0] p1_raw;
		int unsigned               roll;
		p0_raw = 16'($urandom);
		roll = $urandom_range(99);
		if (roll < 10)
			p1_raw = p0_raw;
		else if (roll < 30)
			p1_raw = p0_raw + 16'($urandom_range(1, 64));
		else
			p1_raw = 16'($urandom);
		configure(8'($urandom), 8'($urandom), 8'($urandom), p0_raw, p1_raw);
	endtask

	// Mostly samples between or near the calibration readings, some anywhere.
	function automatic logic [tpc_pkg::RAW_W-1:0] pick_sample();
		longint      lo;
		longint      hi;
		longint      span;
		longint      s;
		int unsigned roll;
		lo = (model_p0_raw < model_p1_raw) ? model_p0_raw : model_p1_raw;
		hi = (model_p0_raw < model_p1_raw) ? model_p1_raw : model_p0_raw;
		span = hi - lo;
		roll = $urandom_range(99);
		if (roll < 60) begin
			s = lo + longint'($urandom_range(span));
		end else if (roll < 85) begin
			s = lo - span / 2 - 16 + longint'($urandom_range(2 * span + 32));
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
		end else begin
			s = longint'($signed(16'($urandom)));
		end
		return s[tpc_pkg::RAW_W-1:0];
	endfunction

	// Registers at their reset values: equal readings give the error flag.
	task automatic test_reset_defaults();
		model_high_bits    = '0;
		model_p0_degx8_low = '0;
		model_p1_degx8_low = '0;
		model_p0_raw       = '0;
		model_p1_raw       = '0;
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h0000);
	endtask

	// A setting where the result equals the sample, so the clamp boundaries
	// and the sample extremes can be hit exactly. The point1 low bits also
	// check that eighths are floored away.
	task automatic test_clamp_boundaries();
		configure(8'h0C, 8'h00, 8'h27, 16'sd0, 16'sd1000);
		send_sample(16'sd1199);
		send_sample(16'sd1200);
		send_sample(16'sd1198);
		send_sample(-16'sd399);
		send_sample(-16'sd400);
		send_sample(-16'sd398);
		send_sample(16'sd0);
		send_sample(16'h7FFF);
		send_sample(16'h8000);
	endtask

	// Negative quotients truncate toward zero, not toward minus infinity.
	task automatic test_truncation();
		configure(8'h00, 8'h00, 8'h08, 16'sd0, 16'sd3);
		send_sample(-16'sd1);
		send_sample(-16'sd2);
		send_sample(16'sd1);
	endtask

	// Widest and narrowest spans, reversed order, and ignored high bits.
	task automatic test_config_extremes();
		configure(8'hFF, 8'hFF, 8'hFF, 16'h8000, 16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		configure(8'hF3, 8'h00, 8'hFF, 16'h7FFF, 16'h8000);
		send_sample(16'h0000);
		send_sample(16'h7FFF);
		configure(8'hFC, 8'h00, 8'hFF, 16'sd100, 16'sd101);
		send_sample(16'sd100);
		send_sample(16'h8000);
	endtask

	// Equal calibration readings away from zero.
	task automatic test_equal_points();
		configure(8'h05, 8'hA0, 8'h5A, 16'h1234, 16'h1234);
		send_sample(16'h1234);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
	endtask

	// Random samples under changing settings, with a full drain at sample 150 and every 300 after it.
	task automatic test_random_phase(input int sender_pct, input int receiver_pct,
			input int count);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		for (int i = 0; i < count; i++) begin
			if (i % 96 == 0)
				configure_random();
			if (i % 300 == 150)
				wait_drained();
			send_sample(pick_sample());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 51;
		test_reset_defaults();
		test_clamp_boundaries();
		test_truncation();
		test_config_extremes();
		test_equal_points();

		test_random_phase(22, 51, 584);
		test_random_phase(51, 22, 584);
		test_random_phase(0, 0, 584);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_temps.size() != 0) begin
			error_count++;
			$display("%0d expected results never arrived.", expected_temps.size());
		end

		$display("Checked %0d calibrated samples under %0d calibration settings.",
			results_checked, settings_used);
		$display("Of those, %0d were limited and %0d had equal calibration readings.",
			clamped_seen, div_error_seen);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches in total.", error_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
